// ===== rtl/core/cstp_pkg.sv =====
// cstp_pkg: shared types and constants of the two-pass contrast stretch
// no dependencies; imported by the config channel interface and the top level
`default_nettype none

package cstp_pkg;

    // configuration register indexes
    localparam int CFG_IDX_BITS = 2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_OUT_MIN = 2'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_OUT_MAX = 2'd1;

    // item commands
    localparam logic CMD_MEASURE = 1'b0;
    localparam logic CMD_MAP     = 1'b1;

    // sequencer states, one-hot
    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_MUL  = 5'b00010,
        S_PREP = 5'b00100,
        S_DIV  = 5'b01000,
        S_DONE = 5'b10000
    } t_state;

endpackage

`default_nettype wire

// ===== rtl/core/cstp_if.sv =====
// cstp_if: valid/ready channel interfaces for pixel items, results and config writes
// depends on cstp_pkg for the register index width
`default_nettype none

interface cstp_pix_if #(
    parameter int PIXEL_BITS = 8
) ();
    logic                  valid;
    logic                  ready;
    logic                  command;
    logic [PIXEL_BITS-1:0] pixel;
    logic                  first_of_frame;
    logic                  last_of_frame;

    modport source (output valid, command, pixel, first_of_frame, last_of_frame,
                    input ready);
    modport sink   (input valid, command, pixel, first_of_frame, last_of_frame,
                    output ready);
endinterface

interface cstp_res_if #(
    parameter int PIXEL_BITS = 8
) ();
    logic                  valid;
    logic                  ready;
    logic [PIXEL_BITS-1:0] mapped_pixel;
    logic                  last_out;

    modport source (output valid, mapped_pixel, last_out, input ready);
    modport sink   (input valid, mapped_pixel, last_out, output ready);
endinterface

interface cstp_cfg_if
    import cstp_pkg::*;
#(
    parameter int PIXEL_BITS = 8
) ();
    logic                    valid;
    logic                    ready;
    logic [CFG_IDX_BITS-1:0] index;
    logic [PIXEL_BITS-1:0]   data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/contrast_stretch_two_pass_unit.sv =====
// contrast_stretch_two_pass_unit: min/max measurement and bit-serial linear stretch
// depends on cstp_pkg and the channel interfaces in cstp_if.sv
//
//  channel  dir  payload                                          beat taken when
//  i_pix    in   command, pixel, first_of_frame, last_of_frame    valid && ready
//  o_res    out  mapped_pixel, last_out                           valid && ready
//  i_cfg    in   index (0 out_min, 1 out_max), data               valid && ready
//
//  a map beat runs the shift-add multiplier (PIXEL_BITS steps) and then the restoring
//  divider (2*PIXEL_BITS+1 steps), one bit a cycle; a flat or unmeasured frame skips
//  both. a measure beat leaves the unit idle and ready for the next beat.
//  reset is synchronous, active low; it restores out_min 0, out_max full scale and
//  clears the measured range. a result waits in the output register while the next
//  beat is taken; the sequencer holds in its final state only while that register is full.
`default_nettype none

module contrast_stretch_two_pass_unit
    import cstp_pkg::*;
#(
    parameter int PIXEL_BITS = 8
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    cstp_pix_if.sink     i_pix,
    cstp_res_if.source   o_res,
    cstp_cfg_if.sink     i_cfg
);

    localparam int PW = PIXEL_BITS;
    localparam int DW = 2 * PW + 1;
    localparam int CW = $clog2(DW);
    localparam logic [PW-1:0] MASK = {PW{1'b1}};

    t_state          r_state, n_state;
    logic [PW-1:0]   r_out_min, r_out_max;
    logic [PW-1:0]   r_min, r_max;
    logic            r_seen;
    logic [CW-1:0]   r_cnt, n_cnt;
    logic [PW-1:0]   r_a, n_a;
    logic [2*PW-1:0] r_prod, n_prod;
    logic [PW-1:0]   r_span, n_span;
    logic [PW:0]     r_rem, n_rem;
    logic [DW-1:0]   r_quo, n_quo;
    logic            r_neg, n_neg;
    logic            r_last, n_last;
    logic            r_out_valid;
    logic [PW-1:0]   r_out_pix;
    logic            r_out_last;

    logic            pix_beat, res_beat, out_load;
    logic [PW:0]     span_out, diff_in, abs_so, abs_d;
    logic            flat;
    logic [PW:0]     mul_sum;
    logic [PW+1:0]   div_t, div_sub;
    logic            div_ge;
    logic [DW:0]     pos_sum;
    logic [PW-1:0]   final_pix;

    assign i_pix.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;
    assign pix_beat    = i_pix.valid && i_pix.ready;
    assign res_beat    = o_res.valid && o_res.ready;
    assign out_load    = (r_state == S_DONE) && (!r_out_valid || o_res.ready);

    assign o_res.valid        = r_out_valid;
    assign o_res.mapped_pixel = r_out_pix;
    assign o_res.last_out     = r_out_last;

    // configuration and measured range
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_min <= '0;
            r_out_max <= MASK;
            r_min     <= MASK;
            r_max     <= '0;
            r_seen    <= 1'b0;
        end else begin
            if (i_cfg.valid && i_cfg.ready) begin
                case (i_cfg.index)
                    CFG_OUT_MIN: r_out_min <= i_cfg.data;
                    CFG_OUT_MAX: r_out_max <= i_cfg.data;
                    default: ;
                endcase
            end
            if (pix_beat && i_pix.command == CMD_MEASURE) begin
                r_seen <= 1'b1;
                if (i_pix.first_of_frame || !r_seen) begin
                    r_min <= i_pix.pixel;
                    r_max <= i_pix.pixel;
                end else begin
                    if (i_pix.pixel < r_min) r_min <= i_pix.pixel;
                    if (i_pix.pixel > r_max) r_max <= i_pix.pixel;
                end
            end
        end
    end

    // operand set-up at the map beat
    always_comb begin
        span_out = {1'b0, r_out_max} - {1'b0, r_out_min};
        diff_in  = {1'b0, i_pix.pixel} - {1'b0, r_min};
        abs_so   = span_out[PW] ? -span_out : span_out;
        abs_d    = diff_in[PW] ? -diff_in : diff_in;
        flat     = !r_seen || (r_max <= r_min);
    end

    // one multiplier bit and one quotient bit per step
    always_comb begin
        mul_sum = {1'b0, r_prod[2*PW-1:PW]} + (r_prod[0] ? {1'b0, r_a} : '0);
        div_t   = {r_rem, r_quo[DW-1]};
        div_ge  = div_t >= {1'b0, r_span, 1'b0};
        div_sub = div_t - {1'b0, r_span, 1'b0};
    end

    // saturating out_min +/- quotient
    always_comb begin
        pos_sum = {{(DW+1-PW){1'b0}}, r_out_min} + {1'b0, r_quo};
        if (r_neg) begin
            if (r_quo > {{(DW-PW){1'b0}}, r_out_min}) final_pix = '0;
            else final_pix = r_out_min - r_quo[PW-1:0];
        end else begin
            if (pos_sum > {{(DW+1-PW){1'b0}}, MASK}) final_pix = MASK;
            else final_pix = pos_sum[PW-1:0];
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_a     = r_a;
        n_prod  = r_prod;
        n_span  = r_span;
        n_rem   = r_rem;
        n_quo   = r_quo;
        n_neg   = r_neg;
        n_last  = r_last;
        case (r_state)
            S_IDLE: begin
                if (pix_beat && i_pix.command == CMD_MAP) begin
                    n_last = i_pix.last_of_frame;
                    n_a    = abs_so[PW-1:0];
                    n_prod = {{PW{1'b0}}, abs_d[PW-1:0]};
                    n_span = r_max - r_min;
                    n_neg  = span_out[PW] ^ diff_in[PW];
                    n_cnt  = CW'(PW - 1);
                    if (flat) begin
                        // no usable range: out_min + 0
                        n_quo   = '0;
                        n_neg   = 1'b0;
                        n_state = S_DONE;
                    end else begin
                        n_state = S_MUL;
                    end
                end
            end
            S_MUL: begin
                n_prod = {mul_sum, r_prod[PW-1:1]};
                n_cnt  = r_cnt - 1'b1;
                if (r_cnt == '0) n_state = S_PREP;
            end
            S_PREP: begin
                // dividend 2*|num| + span over divisor 2*span rounds half away
                n_quo   = {r_prod, 1'b0} + {{(PW+1){1'b0}}, r_span};
                n_rem   = '0;
                n_cnt   = CW'(DW - 1);
                n_state = S_DIV;
            end
            S_DIV: begin
                n_rem  = div_ge ? div_sub[PW:0] : div_t[PW:0];
                n_quo  = {r_quo[DW-2:0], div_ge};
                n_cnt  = r_cnt - 1'b1;
                if (r_cnt == '0) n_state = S_DONE;
            end
            S_DONE: begin
                if (out_load) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            if (out_load) r_out_valid <= 1'b1;
            else if (res_beat) r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_a    <= n_a;
        r_prod <= n_prod;
        r_span <= n_span;
        r_rem  <= n_rem;
        r_quo  <= n_quo;
        r_neg  <= n_neg;
        r_last <= n_last;
        if (out_load) begin
            r_out_pix  <= final_pix;
            r_out_last <= r_last;
        end
    end

    a_map_goes_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pix_beat && i_pix.command == CMD_MAP |=> r_state != S_IDLE)
        else $error("map beat did not start the sequencer");

    a_done_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_DONE && !r_out_valid |=> o_res.valid && r_state == S_IDLE)
        else $error("finished result not loaded into empty output register");

    a_range_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        pix_beat && i_pix.command == CMD_MEASURE |=> r_seen && r_min <= r_max)
        else $error("measured range out of order");

    a_unseen_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_seen |-> r_min == MASK && r_max == '0)
        else $error("range changed with nothing measured");

endmodule

`default_nettype wire
